// ===== sv/pmrc_pkg.sv =====
// Shared types and codes for the per-module register value cache.
// No dependencies; every other file refers to this package by scoped names.
package pmrc_pkg;

    localparam logic [1:0] KIND_STORE     = 2'd0;
    localparam logic [1:0] KIND_READ      = 2'd1;
    localparam logic [1:0] KIND_CLEAR_ONE = 2'd2;
    localparam logic [1:0] KIND_CLEAR_ALL = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DISABLED  = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam int unsigned KEY_W   = 16;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned STAMP_W = 48;
    localparam int unsigned CNT_W   = 32;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    typedef struct packed {
        logic wr_en;
        logic clr_one;
        logic clr_all;
    } mod_ctl_t;

endpackage

// ===== sv/pmrc_slot_mem.sv =====
// Entry memory of the cache: key, value and timestamp of every slot.
// Depends on pmrc_pkg for the slot record type.
module pmrc_slot_mem #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  logic           aclk,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output pmrc_pkg::slot_t rd_data,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  pmrc_pkg::slot_t wr_data
);

    pmrc_pkg::slot_t mem [DEPTH];
    pmrc_pkg::slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pmrc_mod_mem.sv =====
// Per-module record memory: live flag, fill count and last-update time.
// Depends on pmrc_pkg; a valid bit per module makes unwritten records read as zero.
module pmrc_mod_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned MW    = 8,
    parameter int unsigned FW    = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [MW-1:0]                 rd_addr,
    input  pmrc_pkg::mod_ctl_t            ctl,
    input  logic [MW-1:0]                 wr_addr,
    input  logic                          wr_live,
    input  logic [FW-1:0]                 wr_fill,
    input  logic [pmrc_pkg::STAMP_W-1:0]  wr_stamp,
    output logic                          rd_live,
    output logic [FW-1:0]                 rd_fill,
    output logic [pmrc_pkg::STAMP_W-1:0]  rd_stamp
);

    localparam int unsigned RW = 1 + FW + pmrc_pkg::STAMP_W;

    logic [RW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [RW-1:0]    q_reg;
    logic             qv_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= {wr_live, wr_fill, wr_stamp};
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // A cleared record only drops its valid bit; the stale contents are never seen.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end else begin
            if (ctl.clr_all) begin
                valid_reg <= '0;
            end else if (ctl.clr_one) begin
                valid_reg[wr_addr] <= 1'b0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                qv_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_live  = qv_reg ? q_reg[RW-1] : 1'b0;
    assign rd_fill  = qv_reg ? q_reg[RW-2 -: FW] : '0;
    assign rd_stamp = qv_reg ? q_reg[pmrc_pkg::STAMP_W-1:0] : '0;

endmodule

// ===== sv/per_module_register_value_cache_top.sv =====
// Top level of the per-module register value cache: control sequencer,
// statistics counters and result register. Uses pmrc_pkg, pmrc_mod_mem, pmrc_slot_mem.
//
//  channel  direction  handshake                 payload
//  s_       in         s_valid / s_ready         kind, module, address, value, time
//  m_       out        m_valid / m_ready         status, value, times, flag, counters
//  cfg_     in         cfg_valid / cfg_ready     cache enable bit
//
// A store or a read of a module in use reads at most fill slots before its result
// is loaded, where fill is the number of entries of the selected module.
// The key search reads one slot per cycle from the single read port of the slot
// memory, and a hit ends it early. A read of an unused module skips the search;
// clears and disabled items go from the record read straight to finish. The
// sequencer is back in idle on the cycle the result is loaded. Reset clears the
// module records at once through valid bits; the slot memory needs no clearing.
// A stalled result holds in the output register and the next request is taken
// meanwhile, finishing only once it is free. The enable bit is written only
// while the sequencer is idle.
module per_module_register_value_cache_top #(
    parameter int unsigned SLOTS_PER_MODULE = 32,
    parameter int unsigned MODULE_COUNT     = 256
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_kind,
    input  logic [7:0]   s_module_req,
    input  logic [15:0]  s_register_address,
    input  logic [15:0]  s_write_value,
    input  logic [47:0]  s_now_ms,

    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [15:0]  m_read_value,
    output logic [47:0]  m_entry_time,
    output logic [47:0]  m_module_last_update,
    output logic         m_module_has_data,
    output logic [31:0]  m_store_total,
    output logic [31:0]  m_read_total,
    output logic [31:0]  m_hit_total,
    output logic [31:0]  m_miss_total,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_wdata
);

    localparam int unsigned S      = SLOTS_PER_MODULE;
    localparam int unsigned MW     = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
    localparam int unsigned SW     = (S > 1) ? $clog2(S) : 1;
    localparam int unsigned FW     = $clog2(S + 1);
    localparam int unsigned SDEPTH = MODULE_COUNT * S;
    localparam int unsigned AW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int unsigned TW     = pmrc_pkg::STAMP_W;
    localparam int unsigned CW     = pmrc_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MREAD   = 3'd1;
    localparam logic [2:0] ST_SEARCH  = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    // Reduction of the module request modulo the module count, built at elaboration.
    function automatic logic [256*8-1:0] build_mod_lut();
        logic [256*8-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[i*8 +: 8] = 8'(i % MODULE_COUNT);
        end
        return t;
    endfunction

    localparam logic [256*8-1:0] MOD_LUT = build_mod_lut();

    logic [2:0]       state_reg, state_next;
    logic             enable_reg;

    logic [1:0]       kind_reg;
    logic [MW-1:0]    mod_reg;
    logic [15:0]      key_reg;
    logic [15:0]      val_reg;
    logic [TW-1:0]    now_reg;

    logic             rec_live_reg;
    logic [FW-1:0]    rec_fill_reg;
    logic [TW-1:0]    rec_stamp_reg;

    logic [FW-1:0]    issue_idx_reg;
    logic             pend_reg;
    logic [SW-1:0]    pend_idx_reg;
    logic             found_reg;
    logic [SW-1:0]    found_idx_reg;
    logic [15:0]      hit_data_reg;
    logic [TW-1:0]    hit_stamp_reg;

    logic [CW-1:0]    store_cnt_reg, read_cnt_reg, hit_cnt_reg, miss_cnt_reg;

    logic [1:0]       res_status_reg;
    logic [15:0]      res_value_reg;
    logic [TW-1:0]    res_time_reg;
    logic [TW-1:0]    res_last_reg;
    logic             res_has_reg;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [15:0]      m_value_reg;
    logic [TW-1:0]    m_time_reg;
    logic [TW-1:0]    m_last_reg;
    logic             m_has_reg;
    logic [CW-1:0]    m_store_reg, m_read_reg, m_hit_reg, m_miss_reg;

    logic             accept;
    logic [7:0]       mod_in8;
    logic             mrd_live;
    logic [FW-1:0]    mrd_fill;
    logic [TW-1:0]    mrd_stamp;
    pmrc_pkg::mod_ctl_t mod_ctl;
    logic [FW-1:0]    mwr_fill;
    logic [TW-1:0]    mwr_stamp;

    logic             slot_rd_en;
    logic [AW-1:0]    slot_rd_addr;
    pmrc_pkg::slot_t  slot_q;
    logic             slot_we;
    logic [AW-1:0]    slot_wr_addr;
    pmrc_pkg::slot_t  slot_wr_data;

    logic [AW-1:0]    mod_base;
    logic             search_hit;
    logic             room;
    logic             wrote;
    logic             out_free;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    // The enable bit only changes between requests, never under one in progress.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign mod_in8   = MOD_LUT[s_module_req*8 +: 8];

    // Base slot of the selected module; the search offset is added to it.
    assign mod_base   = AW'(mod_reg) * AW'(S);
    assign search_hit = pend_reg && (slot_q.key == key_reg);
    assign room       = (rec_fill_reg < FW'(S));
    assign wrote      = found_reg || room;

    always_comb begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = mod_base + AW'(issue_idx_reg);
        if (state_reg == ST_SEARCH && !search_hit && issue_idx_reg < rec_fill_reg) begin
            slot_rd_en = 1'b1;
        end
    end

    // A store writes either the matching slot or the next free one, or nothing when the module is full.
    assign slot_we      = (state_reg == ST_RESOLVE) && (kind_reg == pmrc_pkg::KIND_STORE)
                          && wrote;
    assign slot_wr_addr = mod_base + (found_reg ? AW'(found_idx_reg) : AW'(rec_fill_reg));
    assign slot_wr_data = '{key: key_reg, data: val_reg, stamp: now_reg};

    always_comb begin
        mod_ctl.wr_en   = (state_reg == ST_RESOLVE) && (kind_reg == pmrc_pkg::KIND_STORE);
        mod_ctl.clr_one = (state_reg == ST_MREAD) && enable_reg
                          && (kind_reg == pmrc_pkg::KIND_CLEAR_ONE);
        mod_ctl.clr_all = (state_reg == ST_MREAD) && enable_reg
                          && (kind_reg == pmrc_pkg::KIND_CLEAR_ALL);
    end

    assign mwr_fill  = (!found_reg && room) ? rec_fill_reg + FW'(1) : rec_fill_reg;
    assign mwr_stamp = wrote ? now_reg : rec_stamp_reg;

    pmrc_mod_mem #(
        .DEPTH(MODULE_COUNT),
        .MW   (MW),
        .FW   (FW)
    ) u_mod_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (mod_in8[MW-1:0]),
        .ctl     (mod_ctl),
        .wr_addr (mod_reg),
        .wr_live (1'b1),
        .wr_fill (mwr_fill),
        .wr_stamp(mwr_stamp),
        .rd_live (mrd_live),
        .rd_fill (mrd_fill),
        .rd_stamp(mrd_stamp)
    );

    pmrc_slot_mem #(
        .DEPTH(SDEPTH),
        .AW   (AW)
    ) u_slot_mem (
        .aclk   (aclk),
        .rd_en  (slot_rd_en),
        .rd_addr(slot_rd_addr),
        .rd_data(slot_q),
        .wr_en  (slot_we),
        .wr_addr(slot_wr_addr),
        .wr_data(slot_wr_data)
    );

    // Sequencer: record read, slot search, update, then hand-off to the output.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MREAD;
                end
            end
            ST_MREAD: begin
                if (!enable_reg || kind_reg == pmrc_pkg::KIND_CLEAR_ONE
                        || kind_reg == pmrc_pkg::KIND_CLEAR_ALL) begin
                    state_next = ST_FINISH;
                end else if (kind_reg == pmrc_pkg::KIND_READ && !mrd_live) begin
                    state_next = ST_RESOLVE;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_hit || (!slot_rd_en && !pend_reg)
                        || (!slot_rd_en && pend_reg)) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            store_cnt_reg <= '0;
            read_cnt_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            issue_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_wdata;
            end
            // In the finish state the hand-off below decides the output valid.
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    pend_reg      <= 1'b0;
                    found_reg     <= 1'b0;
                    issue_idx_reg <= '0;
                end
                ST_MREAD: begin
                    res_value_reg <= '0;
                    res_time_reg  <= '0;
                    if (!enable_reg) begin
                        res_status_reg <= pmrc_pkg::STAT_DISABLED;
                        res_last_reg   <= mrd_stamp;
                        res_has_reg    <= 1'b0;
                    end else if (kind_reg == pmrc_pkg::KIND_CLEAR_ONE
                            || kind_reg == pmrc_pkg::KIND_CLEAR_ALL) begin
                        res_status_reg <= pmrc_pkg::STAT_OK;
                        res_last_reg   <= '0;
                        res_has_reg    <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    pend_reg <= slot_rd_en;
                    if (slot_rd_en) begin
                        pend_idx_reg  <= issue_idx_reg[SW-1:0];
                        issue_idx_reg <= issue_idx_reg + FW'(1);
                    end
                    if (search_hit) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= pend_idx_reg;
                        hit_data_reg  <= slot_q.data;
                        hit_stamp_reg <= slot_q.stamp;
                    end
                end
                ST_RESOLVE: begin
                    if (kind_reg == pmrc_pkg::KIND_STORE) begin
                        res_status_reg <= wrote ? pmrc_pkg::STAT_OK : pmrc_pkg::STAT_FULL;
                        res_last_reg   <= mwr_stamp;
                        res_has_reg    <= (mwr_fill != '0);
                        if (wrote) begin
                            store_cnt_reg <= store_cnt_reg + CW'(1);
                        end
                    end else begin
                        read_cnt_reg <= read_cnt_reg + CW'(1);
                        res_last_reg <= rec_stamp_reg;
                        res_has_reg  <= rec_live_reg && (rec_fill_reg != '0);
                        if (found_reg) begin
                            res_status_reg <= pmrc_pkg::STAT_OK;
                            res_value_reg  <= hit_data_reg;
                            res_time_reg   <= hit_stamp_reg;
                            hit_cnt_reg    <= hit_cnt_reg + CW'(1);
                        end else begin
                            res_status_reg <= pmrc_pkg::STAT_NOT_FOUND;
                            miss_cnt_reg   <= miss_cnt_reg + CW'(1);
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            mod_reg  <= mod_in8[MW-1:0];
            key_reg  <= s_register_address;
            val_reg  <= s_write_value;
            now_reg  <= s_now_ms;
        end
        if (state_reg == ST_MREAD) begin
            rec_live_reg  <= mrd_live;
            rec_fill_reg  <= mrd_fill;
            rec_stamp_reg <= mrd_stamp;
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_status_reg <= res_status_reg;
            m_value_reg  <= res_value_reg;
            m_time_reg   <= res_time_reg;
            m_last_reg   <= res_last_reg;
            m_has_reg    <= res_has_reg;
            m_store_reg  <= store_cnt_reg;
            m_read_reg   <= read_cnt_reg;
            m_hit_reg    <= hit_cnt_reg;
            m_miss_reg   <= miss_cnt_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_read_value         = m_value_reg;
    assign m_entry_time         = m_time_reg;
    assign m_module_last_update = m_last_reg;
    assign m_module_has_data    = m_has_reg;
    assign m_store_total        = m_store_reg;
    assign m_read_total         = m_read_reg;
    assign m_hit_total          = m_hit_reg;
    assign m_miss_total         = m_miss_reg;

    // The search never runs past the fill count of the module.
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (issue_idx_reg <= rec_fill_reg))
        else $error("search index beyond fill count");

    // A module record never holds more entries than it has slots.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH || state_reg == ST_RESOLVE) |-> (rec_fill_reg <= FW'(S)))
        else $error("module fill count exceeds slot count");

    // Slots are written only while a store resolves with the cache enabled.
    a_slot_write: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_we |-> (enable_reg && state_reg == ST_RESOLVE))
        else $error("slot write outside store resolution");

    // A disabled result never reports data in the module.
    a_disabled_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == pmrc_pkg::STAT_DISABLED) |-> !m_has_reg)
        else $error("disabled result reports module data");

endmodule

// ===== tb/tb_per_module_register_value_cache_top.sv =====
// Self-checking testbench for the per-module register value cache top level.
// Depends on pmrc_pkg and the cache RTL; a small scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_per_module_register_value_cache_top;

    localparam int SLOTS = 32;
    localparam int MODS  = 256;

    // Expected content of one result request.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_value;
        logic [47:0] entry_time;
        logic [47:0] last_update;
        logic        data_flag;
        logic [31:0] stores;
        logic [31:0] reads;
        logic [31:0] hits;
        logic [31:0] misses;
    } cache_result_t;

    // Shadow copy of the cache contents plus a queue of pending results.
    class cache_scoreboard;
        bit            enabled;
        bit            live [MODS];
        int            fill [MODS];
        logic [47:0]   mod_stamp [MODS];
        logic [15:0]   keys [MODS][SLOTS];
        logic [15:0]   vals [MODS][SLOTS];
        logic [47:0]   stamps [MODS][SLOTS];
        logic [31:0]   n_store, n_read, n_hit, n_miss;
        cache_result_t pending [$];
        int            mismatches;
        int            checked;

        function new();
            enabled = 0;
            n_store = 0; n_read = 0; n_hit = 0; n_miss = 0;
            mismatches = 0;
            checked = 0;
            for (int m = 0; m < MODS; m++) begin
                live[m] = 0; fill[m] = 0; mod_stamp[m] = '0;
            end
        endfunction

        function void wipe(int m);
            live[m] = 0;
            fill[m] = 0;
            mod_stamp[m] = '0;
        endfunction

        function int find_key(int m, logic [15:0] key);
            for (int i = 0; i < fill[m]; i++)
                if (keys[m][i] == key) return i;
            return -1;
        endfunction

        // Applies one accepted request to the shadow state and queues its result.
        function void note_request(logic [1:0] kind, logic [7:0] mod_sel,
                                   logic [15:0] key, logic [15:0] val, logic [47:0] now);
            cache_result_t r;
            int m;
            int slot;
            m = mod_sel;
            r.status = pmrc_pkg::STAT_OK;
            r.read_value = '0;
            r.entry_time = '0;
            if (!enabled) begin
                r.status = pmrc_pkg::STAT_DISABLED;
            end else if (kind == pmrc_pkg::KIND_STORE) begin
                live[m] = 1;
                slot = find_key(m, key);
                if (slot < 0) begin
                    if (fill[m] >= SLOTS) begin
                        r.status = pmrc_pkg::STAT_FULL;
                    end else begin
                        slot = fill[m];
                        fill[m]++;
                    end
                end
                if (slot >= 0) begin
                    keys[m][slot] = key;
                    vals[m][slot] = val;
                    stamps[m][slot] = now;
                    mod_stamp[m] = now;
                    n_store++;
                end
            end else if (kind == pmrc_pkg::KIND_READ) begin
                n_read++;
                slot = live[m] ? find_key(m, key) : -1;
                if (slot < 0) begin
                    r.status = pmrc_pkg::STAT_NOT_FOUND;
                    n_miss++;
                end else begin
                    r.read_value = vals[m][slot];
                    r.entry_time = stamps[m][slot];
                    n_hit++;
                end
            end else if (kind == pmrc_pkg::KIND_CLEAR_ONE) begin
                wipe(m);
            end else begin
                for (int i = 0; i < MODS; i++) wipe(i);
            end
            r.last_update = mod_stamp[m];
            r.data_flag = enabled && live[m] && fill[m] > 0;
            r.stores = n_store;
            r.reads = n_read;
            r.hits = n_hit;
            r.misses = n_miss;
            pending.push_back(r);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(cache_result_t got);
            cache_result_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with no request waiting");
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d differs", checked);
                    $display("  expected st=%0d val=%h t=%h lu=%h hd=%0d cnt=%0d/%0d/%0d/%0d",
                             exp_r.status, exp_r.read_value, exp_r.entry_time,
                             exp_r.last_update, exp_r.data_flag, exp_r.stores,
                             exp_r.reads, exp_r.hits, exp_r.misses);
                    $display("  actual   st=%0d val=%h t=%h lu=%h hd=%0d cnt=%0d/%0d/%0d/%0d",
                             got.status, got.read_value, got.entry_time,
                             got.last_update, got.data_flag, got.stores,
                             got.reads, got.hits, got.misses);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_module_req;
    logic [15:0] s_register_address;
    logic [15:0] s_write_value;
    logic [47:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_read_value;
    logic [47:0] m_entry_time;
    logic [47:0] m_module_last_update;
    logic        m_module_has_data;
    logic [31:0] m_store_total;
    logic [31:0] m_read_total;
    logic [31:0] m_hit_total;
    logic [31:0] m_miss_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_wdata;

    cache_scoreboard sb;

    // The receiver stall pattern is switched between phases by the stimulus.
    int  stall_mode;
    bit  hold_off;
    int  requests_sent;
    int  clears_seen;
    int  full_seen;

    per_module_register_value_cache_top #(
        .SLOTS_PER_MODULE(SLOTS),
        .MODULE_COUNT(MODS)
    ) i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_kind               (s_kind),
        .s_module_req         (s_module_req),
        .s_register_address   (s_register_address),
        .s_write_value        (s_write_value),
        .s_now_ms             (s_now_ms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_read_value         (m_read_value),
        .m_entry_time         (m_entry_time),
        .m_module_last_update (m_module_last_update),
        .m_module_has_data    (m_module_has_data),
        .m_store_total        (m_store_total),
        .m_read_total         (m_read_total),
        .m_hit_total          (m_hit_total),
        .m_miss_total         (m_miss_total),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_wdata            (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The run is bounded well above the slowest legal run: about 1200 requests, each
    // with its slot search, plus sender gaps and receiver stalls.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Every accepted request is handed to the scoreboard at the rising edge where
    // valid and ready are both high, so the prediction follows acceptance order.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_kind, s_module_req, s_register_address, s_write_value, s_now_ms);
            requests_sent++;
            if (s_kind == pmrc_pkg::KIND_CLEAR_ALL || s_kind == pmrc_pkg::KIND_CLEAR_ONE)
                clears_seen++;
        end
    end

    // Results are sampled at the rising edge and compared field by field.
    always @(posedge aclk) begin
        cache_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = m_status;
            got.read_value = m_read_value;
            got.entry_time = m_entry_time;
            got.last_update = m_module_last_update;
            got.data_flag = m_module_has_data;
            got.stores = m_store_total;
            got.reads = m_read_total;
            got.hits = m_hit_total;
            got.misses = m_miss_total;
            if (m_status == pmrc_pkg::STAT_FULL) full_seen++;
            sb.check_result(got);
        end
    end

    // Receiver: stalls on its own pattern; mode 0 never stalls, mode 1 stalls
    // at random, mode 2 alternates long open and closed windows. A hold-off
    // request closes ready for a long counted stretch.
    initial begin
        int phase_cnt;
        phase_cnt = 0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (hold_off) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 3000; i++) @(negedge aclk);
                hold_off = 0;
                m_ready <= 1'b1;
            end else if (stall_mode == 0) begin
                m_ready <= 1'b1;
            end else if (stall_mode == 1) begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_ready <= ((phase_cnt / 13) % 3) != 0;
            end
        end
    end

    // Drives one request and waits until the block accepts it.
    task automatic send_request(logic [1:0] kind, logic [7:0] mod_sel,
                                logic [15:0] key, logic [15:0] val, logic [47:0] now);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_module_req <= mod_sel;
        s_register_address <= key;
        s_write_value <= val;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Like send_request, but keeps valid high for a back-to-back follower.
    task automatic offer_request(logic [1:0] kind, logic [7:0] mod_sel,
                                 logic [15:0] key, logic [15:0] val, logic [47:0] now,
                                 bit last_in_burst);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_module_req <= mod_sel;
        s_register_address <= key;
        s_write_value <= val;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (last_in_burst) s_valid <= 1'b0;
    endtask

    task automatic write_enable(bit en);
        cfg_valid <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.enabled = en;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived, then lets the block settle
    // for longer than the slowest item.
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [47:0] rand_stamp();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Random burst traffic. Keys come from a small pool per module so reads
    // usually hit and tables sometimes fill; a few modules get wide key ranges.
    task automatic random_phase(int count, int mod_span);
        int sent;
        int burst;
        logic [1:0]  kind;
        logic [7:0]  mod_sel;
        logic [15:0] key;
        int pick;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) kind = pmrc_pkg::KIND_STORE;
                else if (pick < 92) kind = pmrc_pkg::KIND_READ;
                else if (pick < 99) kind = pmrc_pkg::KIND_CLEAR_ONE;
                else kind = pmrc_pkg::KIND_CLEAR_ALL;
                mod_sel = 8'($urandom_range(0, mod_span - 1));
                if ($urandom_range(0, 9) == 0) mod_sel = 8'($urandom_range(0, 255));
                if (mod_sel < 2) key = 16'($urandom_range(0, 40));
                else if ($urandom_range(0, 9) == 0) key = 16'($urandom());
                else key = 16'($urandom_range(0, 15));
                offer_request(kind, mod_sel, key, 16'($urandom()), rand_stamp(),
                              (b == burst - 1) || (sent == count - 1));
                sent++;
            end
            repeat ($urandom_range(0, 30)) @(negedge aclk);
        end
    endtask

    initial begin
        sb = new();
        stall_mode = 0;
        hold_off = 0;
        requests_sent = 0;
        clears_seen = 0;
        full_seen = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = pmrc_pkg::KIND_STORE;
        s_module_req = '0;
        s_register_address = '0;
        s_write_value = '0;
        s_now_ms = '0;
        cfg_valid = 1'b0;
        cfg_wdata = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part: disabled items first, then every kind at the field extremes.
        send_request(pmrc_pkg::KIND_STORE, 8'd0, 16'h0000, 16'h0000, 48'h0);
        send_request(pmrc_pkg::KIND_READ, 8'd255, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        drain();
        write_enable(1'b1);
        send_request(pmrc_pkg::KIND_READ, 8'd7, 16'h1234, 16'h0, 48'h1);
        send_request(pmrc_pkg::KIND_STORE, 8'd0, 16'h0000, 16'h0000, 48'h0);
        send_request(pmrc_pkg::KIND_STORE, 8'd255, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(pmrc_pkg::KIND_READ, 8'd255, 16'hFFFF, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_STORE, 8'd255, 16'hFFFF, 16'hA5A5, 48'h5555_AAAA_5555);
        send_request(pmrc_pkg::KIND_READ, 8'd255, 16'hFFFF, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_READ, 8'd255, 16'h0001, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_READ, 8'd0, 16'h0000, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_CLEAR_ONE, 8'd255, 16'h0, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_READ, 8'd255, 16'hFFFF, 16'h0, 48'h0);
        // Fill module 9 completely, then try one more key so the table reports full.
        for (int i = 0; i < SLOTS + 1; i++)
            send_request(pmrc_pkg::KIND_STORE, 8'd9, 16'(16'h100 + i), 16'(i),
                         48'(48'h10 + i));
        send_request(pmrc_pkg::KIND_STORE, 8'd9, 16'h100, 16'hBEEF, 48'h99);
        send_request(pmrc_pkg::KIND_READ, 8'd9, 16'(16'h100 + SLOTS - 1), 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_CLEAR_ALL, 8'd3, 16'h0, 16'h0, 48'h0);
        send_request(pmrc_pkg::KIND_READ, 8'd9, 16'h100, 16'h0, 48'h0);
        drain();

        // Turning the cache off keeps its contents and counters.
        write_enable(1'b0);
        send_request(pmrc_pkg::KIND_STORE, 8'd1, 16'h5, 16'h5, 48'h5);
        send_request(pmrc_pkg::KIND_CLEAR_ALL, 8'd1, 16'h0, 16'h0, 48'h0);
        drain();
        write_enable(1'b1);

        stall_mode = 0;
        random_phase(300, 8);
        drain();

        // Long receiver hold-off while the sender keeps offering requests.
        stall_mode = 1;
        hold_off = 1;
        random_phase(250, 4);
        drain();

        write_enable(1'b0);
        stall_mode = 2;
        random_phase(60, 256);
        drain();
        write_enable(1'b1);

        stall_mode = 1;
        random_phase(400, 3);
        stall_mode = 2;
        random_phase(100, 256);
        drain();

        $display("Covered %0d requests, %0d clears and %0d full-table results,",
                 requests_sent, clears_seen, full_seen);
        $display("with enable toggled and a long output stall; %0d results checked.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
